// ===== src/single_tube_time_display_sequencer_unit_macros.svh =====
// Assertion helpers for the sequencer RTL.
`ifndef SINGLE_TUBE_TIME_DISPLAY_SEQUENCER_UNIT_MACROS_SVH
`define SINGLE_TUBE_TIME_DISPLAY_SEQUENCER_UNIT_MACROS_SVH

// Check out of reset only.
`define STDSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every edge, reset included.
`define STDSS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/stdss_pkg.sv =====
package stdss_pkg;

  typedef struct packed {
    logic [10:0] wake_minute;
    logic [10:0] sleep_minute;
    logic        led_animated;
    logic [15:0] intro_period;
    logic [15:0] digit_period;
    logic [15:0] pause_period;
  } cfg_t;

  typedef struct packed {
    logic       mode;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [7:0] repeat_count;
  } in_beat_t;

  typedef struct packed {
    logic [3:0] digit;
    logic       tube_lit;
    logic [2:0] led_action;
    logic       busy_res;
  } out_beat_t;

  localparam logic [2:0] CFG_WAKE_MINUTE  = 3'd0;
  localparam logic [2:0] CFG_SLEEP_MINUTE = 3'd1;
  localparam logic [2:0] CFG_LED_ANIMATED = 3'd2;
  localparam logic [2:0] CFG_INTRO_PERIOD = 3'd3;
  localparam logic [2:0] CFG_DIGIT_PERIOD = 3'd4;
  localparam logic [2:0] CFG_PAUSE_PERIOD = 3'd5;

  localparam logic [10:0] WAKE_MINUTE_RST  = 11'd0;
  localparam logic [10:0] SLEEP_MINUTE_RST = 11'd1439;
  localparam logic [15:0] INTRO_PERIOD_RST = 16'd50;
  localparam logic [15:0] DIGIT_PERIOD_RST = 16'd300;
  localparam logic [15:0] PAUSE_PERIOD_RST = 16'd2000;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_INIT    = 3'd1;
  localparam logic [2:0] PH_INTRO   = 3'd2;
  localparam logic [2:0] PH_SHOW    = 3'd3;
  localparam logic [2:0] PH_PAUSE   = 3'd4;
  localparam logic [2:0] PH_CLEANUP = 3'd5;

  localparam logic [2:0] LED_NONE     = 3'd0;
  localparam logic [2:0] LED_OFF      = 3'd1;
  localparam logic [2:0] LED_LOCK     = 3'd2;
  localparam logic [2:0] LED_LOCK_ON  = 3'd3;
  localparam logic [2:0] LED_RESTORE  = 3'd4;

  localparam logic [3:0] INTRO_START  = 4'd9;
  localparam logic [3:0] INTRO_LAST   = 4'd9;

  // Exact for values below 64: v * 205 / 2048.
  function automatic logic [3:0] div10(input logic [5:0] v);
    logic [13:0] p;
    p = {8'd0, v} * 14'd205;
    return {1'b0, p[13:11]};
  endfunction

  function automatic logic [3:0] mod10(input logic [5:0] v);
    logic [5:0] q;
    logic [5:0] r;
    q = {2'b00, div10(v)};
    r = v - q * 6'd10;
    return r[3:0];
  endfunction

endpackage

// ===== src/stdss_in_if.sv =====
interface stdss_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [4:0] hour;
  logic [5:0] minute;
  logic [7:0] repeat_count;

  modport source (output valid, output mode, output hour, output minute,
                  output repeat_count, input ready);
  modport sink (input valid, input mode, input hour, input minute,
                input repeat_count, output ready);
endinterface

// ===== src/stdss_out_if.sv =====
interface stdss_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] digit;
  logic       tube_lit;
  logic [2:0] led_action;
  logic       busy_res;

  modport source (output valid, output digit, output tube_lit, output led_action,
                  output busy_res, input ready);
  modport sink (input valid, input digit, input tube_lit, input led_action,
                input busy_res, output ready);
endinterface

// ===== src/stdss_cfg_regs.sv =====
module stdss_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_wdata,
  output stdss_pkg::cfg_t     cfg
);

  stdss_pkg::cfg_t cfg_r;
  stdss_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        stdss_pkg::CFG_WAKE_MINUTE:  cfg_nxt.wake_minute  = cfg_wdata[10:0];
        stdss_pkg::CFG_SLEEP_MINUTE: cfg_nxt.sleep_minute = cfg_wdata[10:0];
        stdss_pkg::CFG_LED_ANIMATED: cfg_nxt.led_animated = cfg_wdata[0];
        stdss_pkg::CFG_INTRO_PERIOD: cfg_nxt.intro_period = cfg_wdata;
        stdss_pkg::CFG_DIGIT_PERIOD: cfg_nxt.digit_period = cfg_wdata;
        stdss_pkg::CFG_PAUSE_PERIOD: cfg_nxt.pause_period = cfg_wdata;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wake_minute  <= stdss_pkg::WAKE_MINUTE_RST;
      cfg_r.sleep_minute <= stdss_pkg::SLEEP_MINUTE_RST;
      cfg_r.led_animated <= 1'b0;
      cfg_r.intro_period <= stdss_pkg::INTRO_PERIOD_RST;
      cfg_r.digit_period <= stdss_pkg::DIGIT_PERIOD_RST;
      cfg_r.pause_period <= stdss_pkg::PAUSE_PERIOD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/stdss_core.sv =====
module stdss_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  stdss_pkg::in_beat_t  item,
  input  stdss_pkg::cfg_t      cfg,
  output stdss_pkg::out_beat_t res
);

  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  frame_r, frame_nxt;
  logic [7:0]  shows_r, shows_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  minute_r, minute_nxt;
  logic [7:0]  target_r, target_nxt;
  logic [3:0]  shown_r, shown_nxt;
  logic        lit_r, lit_nxt;

  logic [2:0]  led;
  logic [15:0] elapsed_inc;
  logic [10:0] minute_of_day;
  logic        asleep;
  logic [7:0]  target_eff;
  logic        last_showing;

  assign elapsed_inc   = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;
  assign minute_of_day = {hour_r, 6'b000000} - {4'b0000, hour_r, 2'b00}
                         + {5'b00000, minute_r};
  assign asleep = (cfg.wake_minute < cfg.sleep_minute)
                  ? (minute_of_day < cfg.wake_minute || minute_of_day > cfg.sleep_minute)
                  : (minute_of_day < cfg.wake_minute && minute_of_day > cfg.sleep_minute);
  assign target_eff   = (target_r == 8'd0) ? 8'd1 : target_r;
  assign last_showing = ({1'b0, shows_r} + 9'd1) >= {1'b0, target_eff};

  always_comb begin
    phase_nxt   = phase_r;
    frame_nxt   = frame_r;
    shows_nxt   = shows_r;
    elapsed_nxt = elapsed_r;
    hour_nxt    = hour_r;
    minute_nxt  = minute_r;
    target_nxt  = target_r;
    shown_nxt   = shown_r;
    lit_nxt     = lit_r;
    led         = stdss_pkg::LED_NONE;
    if (item.mode) begin
      hour_nxt    = item.hour;
      minute_nxt  = item.minute;
      target_nxt  = item.repeat_count;
      frame_nxt   = 4'd0;
      shows_nxt   = 8'd0;
      elapsed_nxt = 16'd0;
      phase_nxt   = stdss_pkg::PH_INIT;
    end else begin
      elapsed_nxt = elapsed_inc;
      case (phase_r)
        stdss_pkg::PH_INIT: begin
          if (asleep) begin
            led       = stdss_pkg::LED_OFF;
            phase_nxt = stdss_pkg::PH_IDLE;
          end else begin
            led       = cfg.led_animated ? stdss_pkg::LED_LOCK_ON : stdss_pkg::LED_LOCK;
            phase_nxt = stdss_pkg::PH_INTRO;
          end
        end
        stdss_pkg::PH_INTRO: begin
          if (elapsed_inc >= cfg.intro_period) begin
            elapsed_nxt = 16'd0;
            if (frame_r > stdss_pkg::INTRO_LAST) begin
              frame_nxt = 4'd0;
              lit_nxt   = 1'b0;
              phase_nxt = stdss_pkg::PH_SHOW;
            end else begin
              shown_nxt = stdss_pkg::INTRO_START - frame_r;
              lit_nxt   = 1'b1;
              frame_nxt = frame_r + 4'd1;
            end
          end
        end
        stdss_pkg::PH_SHOW: begin
          if (elapsed_inc >= cfg.digit_period) begin
            elapsed_nxt = 16'd0;
            frame_nxt   = frame_r + 4'd1;
            case (frame_r)
              4'd0: begin
                shown_nxt = stdss_pkg::div10({1'b0, hour_r});
                lit_nxt   = 1'b1;
              end
              4'd2: begin
                shown_nxt = stdss_pkg::mod10({1'b0, hour_r});
                lit_nxt   = 1'b1;
              end
              4'd4: begin
                shown_nxt = stdss_pkg::div10(minute_r);
                lit_nxt   = 1'b1;
              end
              4'd6: begin
                shown_nxt = stdss_pkg::mod10(minute_r);
                lit_nxt   = 1'b1;
              end
              4'd1, 4'd3, 4'd5: lit_nxt = 1'b0;
              default: begin
                frame_nxt = 4'd0;
                lit_nxt   = 1'b0;
                phase_nxt = stdss_pkg::PH_PAUSE;
              end
            endcase
          end
        end
        stdss_pkg::PH_PAUSE: begin
          if (last_showing) begin
            phase_nxt = stdss_pkg::PH_CLEANUP;
          end else if (elapsed_inc >= cfg.pause_period) begin
            elapsed_nxt = 16'd0;
            shows_nxt   = shows_r + 8'd1;
            phase_nxt   = stdss_pkg::PH_SHOW;
          end
        end
        stdss_pkg::PH_CLEANUP: begin
          led       = stdss_pkg::LED_RESTORE;
          frame_nxt = 4'd0;
          shows_nxt = 8'd0;
          phase_nxt = stdss_pkg::PH_IDLE;
        end
        default: phase_nxt = stdss_pkg::PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= stdss_pkg::PH_IDLE;
      frame_r   <= 4'd0;
      shows_r   <= 8'd0;
      elapsed_r <= 16'd0;
      hour_r    <= 5'd0;
      minute_r  <= 6'd0;
      target_r  <= 8'd0;
      shown_r   <= 4'd0;
      lit_r     <= 1'b0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      frame_r   <= frame_nxt;
      shows_r   <= shows_nxt;
      elapsed_r <= elapsed_nxt;
      hour_r    <= hour_nxt;
      minute_r  <= minute_nxt;
      target_r  <= target_nxt;
      shown_r   <= shown_nxt;
      lit_r     <= lit_nxt;
    end
  end

  assign res.digit      = lit_nxt ? shown_nxt : 4'd0;
  assign res.tube_lit   = lit_nxt;
  assign res.led_action = led;
  assign res.busy_res   = (phase_nxt != stdss_pkg::PH_IDLE);

endmodule

// ===== src/single_tube_time_display_sequencer_unit.sv =====
// Time display sequencer for a single tube.
// Input channel in_ch carries one beat per item: mode 1 is a show request with
// hour, minute and repeat_count; mode 0 is one tick that advances the sequence.
// Output channel out_ch returns exactly one beat per input beat: the digit and
// lit flag of the tube, the LED action of that step and the busy flag.
// Each input beat is registered, then one pass through the step logic writes
// its result into the output register.
// Throughput: 1 item per cycle while out_ch.ready is high; the state update
// of one step is a single pass through the step logic, so items follow back
// to back.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 wake
// minute, 1 sleep minute, 2 LED animated, 3 intro, 4 digit, 5 pause period).
// Write only while no item is in flight.
// Reset (rst_n low, synchronous): both stages empty, sequence idle, registers
// back to their defaults.
// When out_ch.ready is low the output beat holds; an empty input register takes
// one more beat, then in_ch.ready stays low until the output drains.
module single_tube_time_display_sequencer_unit (
  input  logic               clk,
  input  logic               rst_n,
  stdss_in_if.sink           in_ch,
  stdss_out_if.source        out_ch,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

`include "single_tube_time_display_sequencer_unit_macros.svh"

  stdss_pkg::cfg_t      cfg;
  stdss_pkg::in_beat_t  in_beat_r;
  stdss_pkg::out_beat_t step_res;
  stdss_pkg::out_beat_t out_beat_r;
  logic                 in_valid_r;
  logic                 out_valid_r;
  logic                 advance;

  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  stdss_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  stdss_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (in_beat_r),
    .cfg     (cfg),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_beat_r.mode         <= in_ch.mode;
      in_beat_r.hour         <= in_ch.hour;
      in_beat_r.minute       <= in_ch.minute;
      in_beat_r.repeat_count <= in_ch.repeat_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_beat_r <= step_res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.digit      = out_beat_r.digit;
  assign out_ch.tube_lit   = out_beat_r.tube_lit;
  assign out_ch.led_action = out_beat_r.led_action;
  assign out_ch.busy_res   = out_beat_r.busy_res;

  `STDSS_ASSERT(a_step_lands, advance |=> out_valid_r, "stepped beat missing at output")
  `STDSS_ASSERT(a_blank_digit, out_valid_r && !out_beat_r.tube_lit |-> out_beat_r.digit == 4'd0, "blank tube with nonzero digit")
  `STDSS_ASSERT(a_led_code, out_valid_r |-> out_beat_r.led_action <= stdss_pkg::LED_RESTORE, "LED action out of range")
  `STDSS_ASSERT(a_stall_blocks, in_valid_r && out_valid_r && !out_ch.ready |-> !in_ch.ready, "input taken while both stages full")
  `STDSS_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !in_valid_r && !out_valid_r, "stages not empty after reset")

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import stdss_pkg::*;

  class tube_sequence_check;
    cfg_t        regs;
    logic [2:0]  phase;
    logic [3:0]  frame_idx;
    logic [7:0]  shows_done;
    logic [15:0] elapsed;
    logic [4:0]  hold_hr;
    logic [5:0]  hold_min;
    logic [7:0]  rep_target;
    logic [3:0]  digit_q;
    logic        lit_q;
    out_beat_t   frames_due[$];
    int          mismatches;

    function new();
      regs.wake_minute  = WAKE_MINUTE_RST;
      regs.sleep_minute = SLEEP_MINUTE_RST;
      regs.led_animated = 1'b0;
      regs.intro_period = INTRO_PERIOD_RST;
      regs.digit_period = DIGIT_PERIOD_RST;
      regs.pause_period = PAUSE_PERIOD_RST;
      phase      = PH_IDLE;
      frame_idx  = '0;
      shows_done = '0;
      elapsed    = '0;
      hold_hr    = '0;
      hold_min   = '0;
      rep_target = '0;
      digit_q    = '0;
      lit_q      = 1'b0;
      mismatches = 0;
    endfunction

    task report(string msg);
      $display("%0t: mismatch: %s", $time, msg);
      mismatches++;
    endtask

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        CFG_WAKE_MINUTE:  regs.wake_minute  = data[10:0];
        CFG_SLEEP_MINUTE: regs.sleep_minute = data[10:0];
        CFG_LED_ANIMATED: regs.led_animated = data[0];
        CFG_INTRO_PERIOD: regs.intro_period = data;
        CFG_DIGIT_PERIOD: regs.digit_period = data;
        CFG_PAUSE_PERIOD: regs.pause_period = data;
        default: ;
      endcase
    endfunction

    function bit busy();
      return phase != PH_IDLE;
    endfunction

    function void light(logic [3:0] d);
      digit_q = d;
      lit_q   = 1'b1;
    endfunction

    function out_beat_t advance(in_beat_t b);
      out_beat_t   r;
      logic [2:0]  led;
      int unsigned m;
      int unsigned target;
      bit          asleep;
      led = LED_NONE;
      if (b.mode) begin
        hold_hr    = b.hour;
        hold_min   = b.minute;
        rep_target = b.repeat_count;
        frame_idx  = '0;
        shows_done = '0;
        elapsed    = '0;
        phase      = PH_INIT;
      end else begin
        if (elapsed != 16'hFFFF) elapsed = elapsed + 16'd1;
        case (phase)
          PH_INIT: begin
            m = int'(hold_hr) * 60 + int'(hold_min);
            if (regs.wake_minute < regs.sleep_minute)
              asleep = (m < regs.wake_minute) || (m > regs.sleep_minute);
            else
              asleep = (m < regs.wake_minute) && (m > regs.sleep_minute);
            if (asleep) begin
              led   = LED_OFF;
              phase = PH_IDLE;
            end else begin
              led   = regs.led_animated ? LED_LOCK_ON : LED_LOCK;
              phase = PH_INTRO;
            end
          end
          PH_INTRO: begin
            if (elapsed >= regs.intro_period) begin
              elapsed = '0;
              if (frame_idx > INTRO_LAST) begin
                frame_idx = '0;
                lit_q     = 1'b0;
                phase     = PH_SHOW;
              end else begin
                light(INTRO_START - frame_idx);
                frame_idx = frame_idx + 4'd1;
              end
            end
          end
          PH_SHOW: begin
            if (elapsed >= regs.digit_period) begin
              elapsed = '0;
              case (frame_idx)
                4'd0: light(4'(hold_hr / 5'd10));
                4'd2: light(4'(hold_hr % 5'd10));
                4'd4: light(4'(hold_min / 6'd10));
                4'd6: light(4'(hold_min % 6'd10));
                4'd1, 4'd3, 4'd5: lit_q = 1'b0;
                default: begin
                  frame_idx = '0;
                  lit_q     = 1'b0;
                  phase     = PH_PAUSE;
                end
              endcase
              if (phase == PH_SHOW) frame_idx = frame_idx + 4'd1;
            end
          end
          PH_PAUSE: begin
            target = (rep_target == 8'd0) ? 1 : int'(rep_target);
            if (int'(shows_done) + 1 >= target) begin
              phase = PH_CLEANUP;
            end else if (elapsed >= regs.pause_period) begin
              elapsed    = '0;
              shows_done = shows_done + 8'd1;
              phase      = PH_SHOW;
            end
          end
          PH_CLEANUP: begin
            led        = LED_RESTORE;
            frame_idx  = '0;
            shows_done = '0;
            phase      = PH_IDLE;
          end
          default: phase = PH_IDLE;
        endcase
      end
      r.digit      = lit_q ? digit_q : 4'd0;
      r.tube_lit   = lit_q;
      r.led_action = led;
      r.busy_res   = (phase != PH_IDLE);
      return r;
    endfunction

    function void note_beat(in_beat_t b);
      frames_due.push_back(advance(b));
    endfunction

    task check_beat(out_beat_t got);
      out_beat_t want;
      if (frames_due.size() == 0) begin
        report("result beat with nothing pending");
        return;
      end
      want = frames_due.pop_front();
      if (got.digit !== want.digit)
        report($sformatf("digit got %0d want %0d", got.digit, want.digit));
      if (got.tube_lit !== want.tube_lit)
        report($sformatf("tube_lit got %0d want %0d", got.tube_lit, want.tube_lit));
      if (got.led_action !== want.led_action)
        report($sformatf("led_action got %0d want %0d", got.led_action, want.led_action));
      if (got.busy_res !== want.busy_res)
        report($sformatf("busy_res got %0d want %0d", got.busy_res, want.busy_res));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;
  int          in_calm;
  int          out_calm;

  stdss_in_if  in_ch();
  stdss_out_if out_ch();

  tube_sequence_check sb = new();

  single_tube_time_display_sequencer_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 4);
  endfunction

  task automatic send_beat(input in_beat_t b);
    int gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= b.mode;
    in_ch.hour         <= b.hour;
    in_ch.minute       <= b.minute;
    in_ch.repeat_count <= b.repeat_count;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_beat(b);
  endtask

  task automatic send_tick();
    in_beat_t b;
    b      = in_beat_t'($urandom);
    b.mode = 1'b0;
    send_beat(b);
  endtask

  task automatic send_show(input logic [4:0] hr, input logic [5:0] mn,
                           input logic [7:0] rep);
    in_beat_t b;
    b.mode         = 1'b1;
    b.hour         = hr;
    b.minute       = mn;
    b.repeat_count = rep;
    send_beat(b);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.frames_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_regs(input logic [15:0] wake, input logic [15:0] sleep_at,
                           input logic [15:0] anim, input logic [15:0] intro,
                           input logic [15:0] dig, input logic [15:0] pause);
    logic [2:0]  idx[6];
    logic [15:0] val[6];
    idx[0] = CFG_WAKE_MINUTE;  val[0] = wake;
    idx[1] = CFG_SLEEP_MINUTE; val[1] = sleep_at;
    idx[2] = CFG_LED_ANIMATED; val[2] = anim;
    idx[3] = CFG_INTRO_PERIOD; val[3] = intro;
    idx[4] = CFG_DIGIT_PERIOD; val[4] = dig;
    idx[5] = CFG_PAUSE_PERIOD; val[5] = pause;
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly complete show sequences; some are cut short by a restart.
  task automatic run_sequences(input int budget);
    int          sent;
    int          cut;
    int          sel;
    logic [4:0]  hr;
    logic [5:0]  mn;
    logic [7:0]  rep;
    sent = 0;
    while (sent < budget) begin
      hr  = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 23));
      mn  = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 59));
      sel = $urandom_range(0, 9);
      if (sel < 6)      rep = 8'($urandom_range(0, 3));
      else if (sel < 9) rep = 8'($urandom_range(4, 8));
      else              rep = 8'($urandom_range(0, 255));
      send_show(hr, mn, rep);
      sent++;
      cut = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 20) : -1;
      while (sb.busy() && sent < budget && cut != 0) begin
        send_tick();
        sent++;
        if (cut > 0) cut--;
      end
      repeat ($urandom_range(0, 2)) begin
        if (sent < budget) begin
          send_tick();
          sent++;
        end
      end
    end
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      out_beat_t got;
      int        stall;
      stall = draw_gap(out_calm);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      got.digit      = out_ch.digit;
      got.tube_lit   = out_ch.tube_lit;
      got.led_action = out_ch.led_action;
      got.busy_res   = out_ch.busy_res;
      sb.check_beat(got);
    end
  end

  initial begin
    logic [15:0] w;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_WAKE_MINUTE;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.mode         <= 1'b0;
    in_ch.hour         <= '0;
    in_ch.minute       <= '0;
    in_ch.repeat_count <= '0;
    in_calm  = 0;
    out_calm = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults straight out of reset
    run_sequences(80);
    drain();

    // zero periods: every step fires on each tick
    load_regs(16'd0, 16'd1439, 16'd0, 16'd0, 16'd0, 16'd0);
    send_show(5'd23, 6'd59, 8'd0);
    repeat (23) send_tick();
    send_show(5'd31, 6'd63, 8'd255);
    send_tick();
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: load_regs(16'd420, 16'd1320, 16'd1, 16'd1, 16'd2, 16'd1);
        1: load_regs(16'd1439, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        2: begin
          w = 16'($urandom_range(0, 1439));
          load_regs(w, w, 16'd1, 16'd2, 16'd1, 16'd3);
        end
        3: load_regs(16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        default: begin
          if ($urandom_range(0, 1) == 0)
            load_regs(16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                      16'($urandom_range(0, 3)));
          else
            load_regs(16'($urandom_range(0, 1439)), 16'($urandom_range(0, 1439)),
                      16'($urandom_range(0, 1)), 16'($urandom_range(0, 3)),
                      16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)));
        end
      endcase
      run_sequences(ph == 3 ? 20 : 50);
      drain();
    end

    if (sb.frames_due.size() != 0)
      sb.report($sformatf("%0d expected beats never arrived", sb.frames_due.size()));
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+src
src/stdss_pkg.sv
src/stdss_in_if.sv
src/stdss_out_if.sv
src/stdss_cfg_regs.sv
src/stdss_core.sv
src/single_tube_time_display_sequencer_unit.sv
tb/testbench.sv
